### rtl/core/rfm_pkg.sv
package rfm_pkg;

   // Event codes of the input channel.
   localparam logic [1:0] CMD_OVERFLOW = 2'd0;
   localparam logic [1:0] CMD_CAPTURE  = 2'd1;
   localparam logic [1:0] CMD_POLL     = 2'd2;

   // Result status codes.
   localparam logic [1:0] STATUS_MEASURED  = 2'd0;
   localparam logic [1:0] STATUS_NO_SIGNAL = 2'd1;
   localparam logic [1:0] STATUS_ZERO_TIME = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_CLOCK_HZ      = 2'd0;
   localparam logic [1:0] CSR_REPORT_TICKS  = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT_TICKS = 2'd2;

   localparam logic [31:0] CLOCK_HZ_RESET      = 32'd16000000;
   localparam logic [31:0] REPORT_TICKS_RESET  = 32'd1000;
   localparam logic [31:0] TIMEOUT_TICKS_RESET = 32'd2000;

   localparam int FREQ_BITS = 40;
   localparam logic [FREQ_BITS-1:0] FREQ_MAX = '1;

   // Kind of report handed from the front to the back.
   localparam logic JOB_MEASURE = 1'b0;
   localparam logic JOB_TIMEOUT = 1'b1;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] capture_value;
      logic [31:0] elapsed_ticks;
   } req_type;

   typedef struct packed {
      logic [FREQ_BITS-1:0] frequency;
      logic [1:0]           status;
   } rsp_type;

   typedef struct packed {
      logic [31:0] clock_hz;
      logic [31:0] report_ticks;
      logic [31:0] timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] total_captures;
      logic [31:0] window_time;
   } job_type;

endpackage

### rtl/core/rfm_front.sv
module rfm_front
   import rfm_pkg::*;
#(
   parameter int CAPTURE_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_data,
   output logic    req_full,
   input  cfg_type cfg,
   input  logic    job_full,
   output logic    job_push,
   output job_type job_data
);

   localparam int CAP_KEEP = (CAPTURE_BITS < 16) ? CAPTURE_BITS : 16;
   localparam logic [15:0] CAP_MASK = 16'((64'd1 << CAP_KEEP) - 64'd1);

   logic [7:0]  ovf_ff, ovf_in;
   logic [7:0]  pend_ff, pend_in;
   logic [15:0] latest_ff, latest_in;
   logic [15:0] prev_ff, prev_in;
   logic [31:0] ttime_ff, ttime_in;
   logic [31:0] tcaps_ff, tcaps_in;
   logic [31:0] interval_ff, interval_in;

   logic        accept;
   logic [31:0] interval_sum;
   logic [31:0] span;
   logic [31:0] time_sum;
   logic [31:0] caps_sum;

   assign req_full = job_full;
   assign accept   = req_push && !job_full;

   assign interval_sum = interval_ff + req_data.elapsed_ticks;
   // The overflow count is worth one full capture timer period each.
   assign span = {16'b0, latest_ff} - {16'b0, prev_ff} + ({24'b0, ovf_ff} << CAPTURE_BITS);
   assign time_sum = ttime_ff + span;
   assign caps_sum = tcaps_ff + {24'b0, pend_ff};

   always_comb begin
      ovf_in      = ovf_ff;
      pend_in     = pend_ff;
      latest_in   = latest_ff;
      prev_in     = prev_ff;
      ttime_in    = ttime_ff;
      tcaps_in    = tcaps_ff;
      interval_in = interval_ff;
      job_push    = 1'b0;
      job_data.kind           = JOB_MEASURE;
      job_data.total_captures = caps_sum;
      job_data.window_time    = time_sum;
      if (accept) begin
         case (req_data.cmd)
            CMD_OVERFLOW: begin
               ovf_in = ovf_ff + 8'd1;
            end
            CMD_CAPTURE: begin
               latest_in = req_data.capture_value & CAP_MASK;
               pend_in   = pend_ff + 8'd1;
            end
            CMD_POLL: begin
               interval_in = interval_sum;
               if (pend_ff != 8'd0) begin
                  prev_in  = latest_ff;
                  pend_in  = 8'd0;
                  ovf_in   = 8'd0;
                  ttime_in = time_sum;
                  tcaps_in = caps_sum;
                  if (interval_sum > cfg.report_ticks) begin
                     job_push    = 1'b1;
                     ttime_in    = '0;
                     tcaps_in    = '0;
                     interval_in = '0;
                  end
               end else if (interval_sum > cfg.timeout_ticks) begin
                  job_push      = 1'b1;
                  job_data.kind = JOB_TIMEOUT;
                  ttime_in      = '0;
                  tcaps_in      = '0;
                  interval_in   = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ovf_ff      <= '0;
         pend_ff     <= '0;
         latest_ff   <= '0;
         prev_ff     <= '0;
         ttime_ff    <= '0;
         tcaps_ff    <= '0;
         interval_ff <= '0;
      end else begin
         ovf_ff      <= ovf_in;
         pend_ff     <= pend_in;
         latest_ff   <= latest_in;
         prev_ff     <= prev_in;
         ttime_ff    <= ttime_in;
         tcaps_ff    <= tcaps_in;
         interval_ff <= interval_in;
      end
   end

endmodule

### rtl/core/rfm_job_queue.sv
module rfm_job_queue
   import rfm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    valid,
   output job_type pop_data
);

   job_type     entry_ff [2];
   logic        wptr_ff;
   logic        rptr_ff;
   logic [1:0]  count_ff;
   logic        do_push;
   logic        do_pop;

   assign full     = (count_ff == 2'd2);
   assign valid    = (count_ff != 2'd0);
   assign pop_data = entry_ff[rptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (do_push) begin
            wptr_ff <= !wptr_ff;
         end
         if (do_pop) begin
            rptr_ff <= !rptr_ff;
         end
         count_ff <= count_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
   end

endmodule

### rtl/core/rfm_back.sv
module rfm_back
   import rfm_pkg::*;
#(
   parameter int FRACTION_BITS = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        job_valid,
   input  job_type     job_data,
   output logic        job_pop,
   input  logic [31:0] clock_hz,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output rsp_type     rsp_data
);

   // One quotient bit per step: 64 integer bits plus the fraction bits.
   localparam int STEPS  = 64 + FRACTION_BITS;
   localparam int STEP_W = $clog2(STEPS);

   typedef enum logic [1:0] {
      IDLE,
      MULTIPLY,
      DIVIDE
   } state_type;

   state_type             state_ff;
   logic [31:0]           caps_ff;
   logic [31:0]           den_ff;
   logic [63:0]           dividend_ff;
   logic [31:0]           rem_ff;
   logic [FREQ_BITS-1:0]  quo_ff;
   logic                  sat_ff;
   logic [STEP_W-1:0]     step_ff;
   logic                  res_valid_ff;
   rsp_type               res_ff;

   logic                  start;
   logic [32:0]           trial;
   logic                  qbit;
   logic [31:0]           rem_in;
   logic [FREQ_BITS-1:0]  quo_in;
   logic                  sat_in;

   assign start   = (state_ff == IDLE) && job_valid && !res_valid_ff;
   assign job_pop = start;

   // Restoring division step: the remainder always stays below the divisor.
   assign trial  = {rem_ff, dividend_ff[63]};
   assign qbit   = (trial >= {1'b0, den_ff});
   assign rem_in = qbit ? 32'(trial - {1'b0, den_ff}) : trial[31:0];
   assign quo_in = {quo_ff[FREQ_BITS-2:0], qbit};
   assign sat_in = sat_ff | quo_ff[FREQ_BITS-1];

   assign rsp_empty = !res_valid_ff;
   assign rsp_data  = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         res_valid_ff <= 1'b0;
      end else begin
         if (rsp_pop && res_valid_ff) begin
            res_valid_ff <= 1'b0;
         end
         case (state_ff)
            IDLE: begin
               if (start) begin
                  caps_ff <= job_data.total_captures;
                  den_ff  <= job_data.window_time;
                  if (job_data.kind == JOB_TIMEOUT) begin
                     res_valid_ff     <= 1'b1;
                     res_ff.frequency <= '0;
                     res_ff.status    <= STATUS_NO_SIGNAL;
                  end else if (job_data.window_time == 32'd0) begin
                     res_valid_ff     <= 1'b1;
                     res_ff.frequency <= '0;
                     res_ff.status    <= STATUS_ZERO_TIME;
                  end else begin
                     state_ff <= MULTIPLY;
                  end
               end
            end
            MULTIPLY: begin
               dividend_ff <= {32'b0, caps_ff} * {32'b0, clock_hz};
               rem_ff      <= '0;
               quo_ff      <= '0;
               sat_ff      <= 1'b0;
               step_ff     <= STEP_W'(STEPS - 1);
               state_ff    <= DIVIDE;
            end
            DIVIDE: begin
               dividend_ff <= {dividend_ff[62:0], 1'b0};
               rem_ff      <= rem_in;
               quo_ff      <= quo_in;
               sat_ff      <= sat_in;
               step_ff     <= step_ff - STEP_W'(1);
               if (step_ff == '0) begin
                  res_valid_ff     <= 1'b1;
                  res_ff.frequency <= sat_in ? FREQ_MAX : quo_in;
                  res_ff.status    <= STATUS_MEASURED;
                  state_ff         <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

endmodule

### rtl/core/reciprocal_frequency_meter.sv
// Reciprocal frequency meter.
// Input channel (req_push/req_full): timer overflow, capture and poll events.
// Overflow and capture events only update counters; a poll may close a
// measurement window and produce one result on the rsp_ channel.
// The front end handles each event as soon as it is taken, so events can
// be pushed back to back while req_full is low.
// A report is queued in a two-entry job queue. The back end turns a
// measured report into captures * clock_hz / total time, with FRACTION_BITS
// fraction bits, using a 32x32 multiply and a restoring divider that yields
// one quotient bit per cycle. Zero-frequency reports (no signal, zero
// total time) are set directly from the idle state. A measured report
// occupies the back end until its last quotient bit.
// If rsp_pop stays low, the result holds; further reports fill the job
// queue and then req_full rises until the result is popped.
// Configuration writes (csr_) are always ready and are meant for idle times.
// Reset clears all counters and totals and loads the register defaults.
module reciprocal_frequency_meter
   import rfm_pkg::*;
#(
   parameter int CAPTURE_BITS  = 16,
   parameter int FRACTION_BITS = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  req_type     req_data,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   cfg_type cfg_ff;
   logic    job_push;
   logic    job_full;
   job_type job_in_data;
   logic    job_pop;
   logic    job_valid;
   job_type job_out_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.clock_hz      <= CLOCK_HZ_RESET;
         cfg_ff.report_ticks  <= REPORT_TICKS_RESET;
         cfg_ff.timeout_ticks <= TIMEOUT_TICKS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CLOCK_HZ:      cfg_ff.clock_hz      <= csr_wdata;
            CSR_REPORT_TICKS:  cfg_ff.report_ticks  <= csr_wdata;
            CSR_TIMEOUT_TICKS: cfg_ff.timeout_ticks <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   rfm_front #(
      .CAPTURE_BITS(CAPTURE_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .cfg      (cfg_ff),
      .job_full (job_full),
      .job_push (job_push),
      .job_data (job_in_data)
   );

   rfm_job_queue u_job_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in_data),
      .full      (job_full),
      .pop       (job_pop),
      .valid     (job_valid),
      .pop_data  (job_out_data)
   );

   rfm_back #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_data  (job_out_data),
      .job_pop   (job_pop),
      .clock_hz  (cfg_ff.clock_hz),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   // A report is only produced for an accepted poll, so the queue has room.
   assert property (@(posedge clock) disable iff (reset) job_push |-> !job_full)
      else $error("report pushed into a full job queue");

   // The back end only takes a job once the previous result has left.
   assert property (@(posedge clock) disable iff (reset) job_pop |-> rsp_empty)
      else $error("job taken while a result is still waiting");

   // Only a measured result carries a nonzero frequency.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.status != STATUS_MEASURED) |-> (rsp_data.frequency == '0))
      else $error("zero-frequency report with nonzero frequency");

   assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result pending after reset");

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import rfm_pkg::*;

   localparam int CAPTURE_BITS  = 16;
   localparam int FRACTION_BITS = 10;
   localparam int QUOT_BITS     = 64 + FRACTION_BITS;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 120;
   localparam int HOLD_CYCLES   = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   req_type     req_data = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_CLOCK_HZ;
   logic [31:0] csr_wdata = '0;

   // Register copies and measurement state as the meter should hold them.
   logic [31:0] cfg_clock_hz      = CLOCK_HZ_RESET;
   logic [31:0] cfg_report_ticks  = REPORT_TICKS_RESET;
   logic [31:0] cfg_timeout_ticks = TIMEOUT_TICKS_RESET;
   logic [7:0]  ovf_count    = '0;
   logic [7:0]  cap_pending  = '0;
   logic [15:0] cap_latest   = '0;
   logic [15:0] cap_previous = '0;
   logic [31:0] sum_time     = '0;
   logic [31:0] sum_captures = '0;
   logic [31:0] interval_ticks = '0;

   rsp_type pending_reports[$];
   rsp_type want;

   int mismatch_count = 0;
   int events_sent = 0;
   int results_seen = 0;
   int full_stalls = 0;
   int pop_stall = 0;
   int status_count[4] = '{0, 0, 0, 0};
   bit gaps_on = 1'b1;
   bit rsp_hold = 1'b0;

   reciprocal_frequency_meter #(
      .CAPTURE_BITS (CAPTURE_BITS),
      .FRACTION_BITS(FRACTION_BITS)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .rsp_empty(rsp_empty),
      .rsp_pop  (rsp_pop),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic logic [FREQ_BITS-1:0] scaled_frequency(input logic [31:0] captures,
                                                             input logic [31:0] rate,
                                                             input logic [31:0] span);
      logic [QUOT_BITS-1:0] numer;
      logic [QUOT_BITS-1:0] quotient;
      numer = QUOT_BITS'(64'(captures) * 64'(rate));
      numer = numer << FRACTION_BITS;
      quotient = numer / span;
      if (quotient > FREQ_MAX) begin
         return FREQ_MAX;
      end
      return quotient[FREQ_BITS-1:0];
   endfunction

   function automatic void close_window(input logic [1:0] status, input logic [FREQ_BITS-1:0] freq);
      rsp_type report;
      report.frequency = freq;
      report.status = status;
      pending_reports.push_back(report);
      sum_time = '0;
      sum_captures = '0;
      interval_ticks = '0;
   endfunction

   // Applies one accepted event to the expected meter state.
   function automatic void track_event(input req_type item);
      logic [31:0] span;
      case (item.cmd)
         CMD_OVERFLOW: begin
            ovf_count = ovf_count + 8'd1;
         end
         CMD_CAPTURE: begin
            cap_latest = item.capture_value;
            cap_pending = cap_pending + 8'd1;
         end
         CMD_POLL: begin
            interval_ticks = interval_ticks + item.elapsed_ticks;
            if (cap_pending != 0) begin
               span = 32'(cap_latest) - 32'(cap_previous) + (32'(ovf_count) << CAPTURE_BITS);
               sum_time = sum_time + span;
               sum_captures = sum_captures + 32'(cap_pending);
               cap_previous = cap_latest;
               cap_pending = '0;
               ovf_count = '0;
               if (interval_ticks > cfg_report_ticks) begin
                  if (sum_time == 0) begin
                     close_window(STATUS_ZERO_TIME, '0);
                  end else begin
                     close_window(STATUS_MEASURED,
                                  scaled_frequency(sum_captures, cfg_clock_hz, sum_time));
                  end
               end
            end else if (interval_ticks > cfg_timeout_ticks) begin
               close_window(STATUS_NO_SIGNAL, '0);
            end
         end
         default: begin
         end
      endcase
   endfunction

   function automatic void log_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t: mismatch: %s", $time, msg);
      end
   endfunction

   // The field selected by the command carries the value; the others are random.
   function automatic req_type make_event(input logic [1:0] kind, input logic [31:0] value);
      req_type item;
      item.cmd = kind;
      item.capture_value = 16'($urandom);
      item.elapsed_ticks = $urandom;
      if (kind == CMD_CAPTURE) begin
         item.capture_value = value[15:0];
      end else if (kind == CMD_POLL) begin
         item.elapsed_ticks = value;
      end
      return item;
   endfunction

   function automatic logic [31:0] pick_ticks();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return $urandom;
         default: return $urandom_range(0, 700);
      endcase
   endfunction

   // Entered at a falling edge; returns at the falling edge after the transfer.
   task automatic push_event(input req_type item);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_data <= item;
      req_push <= 1'b1;
      @(posedge clock);
      while (req_full) begin
         full_stalls++;
         @(posedge clock);
      end
      track_event(item);
      if (item.cmd != CMD_UNUSED) begin
         events_sent++;
      end
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [31:0] value);
      csr_index <= index;
      csr_wdata <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      case (index)
         CSR_CLOCK_HZ:      cfg_clock_hz = value;
         CSR_REPORT_TICKS:  cfg_report_ticks = value;
         CSR_TIMEOUT_TICKS: cfg_timeout_ticks = value;
         default: begin
         end
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // The back end may still be busy after the last report, so allow for its latency.
   task automatic wait_drained();
      req_push <= 1'b0;
      while (pending_reports.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic configure(input logic [31:0] rate, input logic [31:0] report,
                            input logic [31:0] timeout);
      wait_drained();
      write_csr(CSR_CLOCK_HZ, rate);
      write_csr(CSR_REPORT_TICKS, report);
      write_csr(CSR_TIMEOUT_TICKS, timeout);
   endtask

   // Mostly complete measurement windows with random content, plus stray events.
   task automatic run_traffic(input int count);
      int stop_at;
      int roll;
      stop_at = events_sent + count;
      while (events_sent < stop_at) begin
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            push_event(make_event(2'($urandom_range(0, 3)), $urandom));
         end else if (roll < 20) begin
            push_event(make_event(CMD_POLL, pick_ticks()));
         end else begin
            repeat ($urandom_range(1, 4)) begin
               if ($urandom_range(0, 3) == 0) begin
                  repeat ($urandom_range(1, 3)) push_event(make_event(CMD_OVERFLOW, '0));
               end
               push_event(make_event(CMD_CAPTURE, $urandom));
            end
            push_event(make_event(CMD_POLL, pick_ticks()));
         end
      end
   endtask

   task automatic test_directed();
      push_event(make_event(CMD_UNUSED, '1));
      push_event(make_event(CMD_CAPTURE, 32'hFFFF));
      push_event(make_event(CMD_OVERFLOW, '0));
      push_event(make_event(CMD_POLL, 32'hFFFF_FFFF));
      // Same capture value again: the window spans no time at all.
      push_event(make_event(CMD_CAPTURE, 32'hFFFF));
      push_event(make_event(CMD_POLL, REPORT_TICKS_RESET + 1));
      push_event(make_event(CMD_POLL, REPORT_TICKS_RESET));
      push_event(make_event(CMD_POLL, TIMEOUT_TICKS_RESET - REPORT_TICKS_RESET + 1));
      // A capture below the previous one wraps the span.
      push_event(make_event(CMD_CAPTURE, '0));
      push_event(make_event(CMD_POLL, REPORT_TICKS_RESET + 1));
      push_event(make_event(CMD_CAPTURE, '0));
      push_event(make_event(CMD_OVERFLOW, '0));
      push_event(make_event(CMD_OVERFLOW, '0));
      push_event(make_event(CMD_CAPTURE, 32'h8000));
      push_event(make_event(CMD_POLL, '0));
      // A poll without captures keeps the overflow count.
      push_event(make_event(CMD_OVERFLOW, '0));
      push_event(make_event(CMD_POLL, REPORT_TICKS_RESET));
      push_event(make_event(CMD_CAPTURE, 32'h0001));
      push_event(make_event(CMD_POLL, 32'h0000_0001));
      push_event(make_event(CMD_UNUSED, '0));
   endtask

   task automatic test_extremes();
      configure('1, '0, '0);
      // One tick of capture time at the fastest clock saturates the result.
      push_event(make_event(CMD_CAPTURE, 32'(cap_previous + 16'd1)));
      push_event(make_event(CMD_POLL, 32'd1));
      push_event(make_event(CMD_POLL, '0));
      push_event(make_event(CMD_POLL, 32'd1));
      push_event(make_event(CMD_CAPTURE, $urandom));
      push_event(make_event(CMD_OVERFLOW, '0));
      push_event(make_event(CMD_OVERFLOW, '0));
      push_event(make_event(CMD_POLL, '0));
      push_event(make_event(CMD_CAPTURE, $urandom));
      push_event(make_event(CMD_POLL, 32'd5));
      run_traffic(60);
      configure(32'd1, '0, '0);
      push_event(make_event(CMD_CAPTURE, $urandom));
      push_event(make_event(CMD_OVERFLOW, '0));
      push_event(make_event(CMD_POLL, 32'd1));
      run_traffic(40);
      // With both limits at the top the interval wraps without any report.
      configure(CLOCK_HZ_RESET, '1, '1);
      push_event(make_event(CMD_POLL, '1));
      push_event(make_event(CMD_POLL, '1));
      push_event(make_event(CMD_CAPTURE, $urandom));
      push_event(make_event(CMD_POLL, '0));
      configure(CLOCK_HZ_RESET, '0, '0);
      push_event(make_event(CMD_CAPTURE, $urandom));
      push_event(make_event(CMD_POLL, 32'd1));
   endtask

   task automatic test_counter_wrap();
      configure($urandom, 32'd10, 32'd20);
      // 256 captures wrap the pending count, so the poll sees no signal.
      repeat (256) push_event(make_event(CMD_CAPTURE, $urandom));
      push_event(make_event(CMD_POLL, 32'd50));
      repeat (257) push_event(make_event(CMD_OVERFLOW, '0));
      push_event(make_event(CMD_CAPTURE, $urandom));
      push_event(make_event(CMD_POLL, 32'd50));
      repeat (255) push_event(make_event(CMD_OVERFLOW, '0));
      push_event(make_event(CMD_CAPTURE, $urandom));
      push_event(make_event(CMD_POLL, 32'd50));
   endtask

   task automatic test_backpressure();
      configure(CLOCK_HZ_RESET, '0, '0);
      fork
         begin
            rsp_hold = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_hold = 1'b0;
         end
      join_none
      repeat (40) begin
         push_event(make_event(CMD_CAPTURE, $urandom));
         push_event(make_event(CMD_POLL, 32'd1));
      end
      repeat (20) push_event(make_event(CMD_POLL, 32'd1));
      wait_drained();
      repeat (30) begin
         push_event(make_event(CMD_CAPTURE, $urandom));
         push_event(make_event(CMD_POLL, pick_ticks()));
      end
   endtask

   task automatic test_random();
      configure(CLOCK_HZ_RESET, REPORT_TICKS_RESET, TIMEOUT_TICKS_RESET);
      run_traffic(220);
      configure($urandom, $urandom_range(0, 300), $urandom_range(0, 900));
      run_traffic(220);
      configure(32'd1, '0, '1);
      run_traffic(180);
      configure($urandom, 32'd400, 32'd1500);
      gaps_on = 1'b0;
      run_traffic(220);
   endtask

   // Result side: random stall bursts, plus a long hold-off when requested.
   always @(negedge clock) begin
      if (reset || rsp_hold) begin
         rsp_pop <= 1'b0;
      end else if (pop_stall > 0) begin
         rsp_pop <= 1'b0;
         pop_stall--;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
         rsp_pop <= 1'b0;
         pop_stall = $urandom_range(0, 4);
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         results_seen++;
         if (pending_reports.size() == 0) begin
            log_mismatch($sformatf("unexpected result freq=%h status=%0d",
                                   rsp_data.frequency, rsp_data.status));
         end else begin
            want = pending_reports.pop_front();
            status_count[want.status]++;
            if (rsp_data.frequency !== want.frequency) begin
               log_mismatch($sformatf("frequency expected %h got %h",
                                      want.frequency, rsp_data.frequency));
            end
            if (rsp_data.status !== want.status) begin
               log_mismatch($sformatf("status expected %0d got %0d",
                                      want.status, rsp_data.status));
            end
         end
      end
   end

   initial begin
      #20_000_000;
      $display("Timed out with %0d results outstanding", pending_reports.size());
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_extremes();
      test_counter_wrap();
      test_backpressure();
      test_random();
      wait_drained();
      $display("Checked %0d results (%0d measured, %0d no signal, %0d zero time) from %0d events",
               results_seen, status_count[STATUS_MEASURED], status_count[STATUS_NO_SIGNAL],
               status_count[STATUS_ZERO_TIME], events_sent);
      $display("Register settings from minimum to maximum; input held off for %0d cycles",
               full_stalls);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

### files.f
rtl/core/rfm_pkg.sv
rtl/core/rfm_front.sv
rtl/core/rfm_job_queue.sv
rtl/core/rfm_back.sv
rtl/core/reciprocal_frequency_meter.sv
bench/tb_top.sv
